// ----- rtl/sha1_message_hasher_core_defines.svh -----
// Assertion macros shared by the SHA-1 hasher RTL.
// Depends on nothing; users must provide clk_i and rst_ni in scope.
`ifndef SHA1_MESSAGE_HASHER_CORE_DEFINES_SVH
`define SHA1_MESSAGE_HASHER_CORE_DEFINES_SVH
`ifndef SYNTH
`define SHA1MH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sha1mh assertion failed");
`define SHA1MH_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("sha1mh assertion failed");
`else
`define SHA1MH_ASSERT(lbl, prop)
`define SHA1MH_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- rtl/sha1mh_pkg.sv -----
// Types and constants of the SHA-1 message hasher.
// No dependencies.
package sha1mh_pkg;

  // One queued input item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       msg_end;
  } item_t;

  // Chaining value after init, H0 in the lowest word.
  localparam logic [4:0][31:0] HInit = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadMark   = 8'h80;
  localparam logic [5:0] PadStop   = 6'd56;
  localparam logic [5:0] BlockLast = 6'd63;
  localparam logic [6:0] RoundLast = 7'd79;
  localparam logic [2:0] LastIdx   = 3'd4;

endpackage

// ----- rtl/sha1_message_hasher_core.sv -----
// Top level of the SHA-1 message hasher: byte stream in, five digest words out.
// Depends on sha1mh_pkg, sha1mh_front and sha1mh_back.
//
//   Channel   Dir  tdata              tuser            tlast
//   s_axis    in   data_byte [7:0]    has_byte         msg_end
//   m_axis    out  digest_word [31:0] word_index [2:0] last_word
//
// The back end takes one queued item per cycle while idle between blocks. A full
// 64-byte block then runs all its rounds through the single shared round unit,
// then a fold step adds the result into the chaining value.
// At message end the 9 to 72 pad bytes go in one per cycle outside the block rounds,
// each padded block is compressed the same way, and five output beats follow.
// The input queue stalls only when full; a stalled output beat holds the back end.
// Reset is asynchronous and active low and restores the SHA-1 initial words.
module sha1_message_hasher_core #(
  parameter int unsigned QDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] has_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser_o,   // [2:0] word_index
  output logic        m_axis_tlast_o
);

  // Queue handshake between the two halves.
  logic              q_valid;
  logic              q_pop;
  sha1mh_pkg::item_t q_item;

  // The front drops items that carry neither a byte nor an end of message,
  // so the back end only sees work that changes state.
  sha1mh_front #(
    .QDepth (QDepth)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .q_valid_o       (q_valid),
    .q_item_o        (q_item),
    .q_pop_i         (q_pop)
  );

  // The back end owns the block buffer, the bit count and the chaining value,
  // and pulls a new item only when it sits idle between blocks.
  sha1mh_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ----- rtl/sha1mh_front.sv -----
// Input side of the SHA-1 hasher: accepts beats, drops empty items, queues the rest.
// Depends on sha1mh_pkg and sha1_message_hasher_core_defines.svh.
`include "sha1_message_hasher_core_defines.svh"
module sha1mh_front #(
  parameter int unsigned QDepth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,
  input  logic              s_axis_tuser_i,
  input  logic              s_axis_tlast_i,
  output logic              q_valid_o,
  output sha1mh_pkg::item_t q_item_o,
  input  logic              q_pop_i
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QDepth);

  sha1mh_pkg::item_t mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;

  assign s_axis_tready_o = (cnt_q != CntFull);
  // An item with neither a byte nor an end changes nothing, so it is not queued.
  assign push      = s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i || s_axis_tlast_i);
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push, q_pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{data_byte: s_axis_tdata_i, has_byte: s_axis_tuser_i,
                           msg_end: s_axis_tlast_i};
    end
  end

  `SHA1MH_ASSERT(a_cnt_max, cnt_q <= CntFull)
  `SHA1MH_ASSERT(a_no_pop_empty, q_pop_i |-> (cnt_q != '0))
  `SHA1MH_ASSERT(a_empty_ptrs, (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))

endmodule

// ----- rtl/sha1mh_back.sv -----
// Work side of the SHA-1 hasher: block buffer, padding, 80-round compression
// and digest output. Depends on sha1mh_pkg and sha1_message_hasher_core_defines.svh.
`include "sha1_message_hasher_core_defines.svh"
module sha1mh_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  sha1mh_pkg::item_t q_item_i,
  output logic              q_pop_o,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [31:0]       m_axis_tdata_o,
  output logic [2:0]        m_axis_tuser_o,
  output logic              m_axis_tlast_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_FOLD,
    S_OUT
  } state_e;

  state_e           state_q;
  logic [4:0][31:0] chain_q;
  logic [60:0]      cnt_q;      // message length in bytes; bit count is this times 8
  logic             pad_q, mark_q, in_len_q, fin_q;
  logic [2:0]       len_k_q;
  logic [6:0]       rnd_q;
  logic [2:0]       widx_q;
  logic             out_vld_q;

  // Buffer doubles as the 16-word schedule window, oldest word on top.
  logic [511:0]     blk_q;
  logic [63:0]      len_q;
  logic [31:0]      a_q, b_q, c_q, d_q, e_q;

  logic        push_en, push_full, use_len;
  logic [7:0]  push_byte;
  logic [5:0]  pos;
  logic [2:0]  len_sh;
  logic [31:0] fn, kc, t_sum, w_new;

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
    rotl = (v << s) | (v >> (6'd32 - {1'b0, s}));
  endfunction

  assign pos     = cnt_q[5:0];
  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;
  assign use_len = mark_q && (in_len_q || (pos == sha1mh_pkg::PadStop));
  assign len_sh  = 3'd7 - len_k_q;

  always_comb begin
    push_en   = 1'b0;
    push_byte = q_item_i.data_byte;
    if (state_q == S_IDLE) begin
      push_en = q_pop_o && q_item_i.has_byte;
    end else if (state_q == S_PAD) begin
      push_en = 1'b1;
      if (!mark_q) begin
        push_byte = sha1mh_pkg::PadMark;
      end else if (use_len) begin
        push_byte = len_q[{len_sh, 3'b000} +: 8];
      end else begin
        push_byte = 8'h00;
      end
    end
  end
  assign push_full = push_en && (pos == sha1mh_pkg::BlockLast);

  always_comb begin
    if (rnd_q < 7'd20) begin
      fn = (b_q & c_q) | (~b_q & d_q);
      kc = sha1mh_pkg::K0;
    end else if (rnd_q < 7'd40) begin
      fn = b_q ^ c_q ^ d_q;
      kc = sha1mh_pkg::K1;
    end else if (rnd_q < 7'd60) begin
      fn = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      kc = sha1mh_pkg::K2;
    end else begin
      fn = b_q ^ c_q ^ d_q;
      kc = sha1mh_pkg::K3;
    end
    t_sum = rotl(a_q, 5'd5) + fn + e_q + kc + blk_q[511:480];
    w_new = rotl(blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ blk_q[511:480], 5'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      chain_q   <= sha1mh_pkg::HInit;
      cnt_q     <= '0;
      pad_q     <= 1'b0;
      mark_q    <= 1'b0;
      in_len_q  <= 1'b0;
      fin_q     <= 1'b0;
      len_k_q   <= '0;
      rnd_q     <= '0;
      widx_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (push_en) begin
        cnt_q <= cnt_q + 61'd1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_pop_o) begin
            if (push_full) begin
              pad_q   <= q_item_i.msg_end;
              rnd_q   <= '0;
              state_q <= S_ROUND;
            end else if (q_item_i.msg_end) begin
              pad_q   <= 1'b1;
              state_q <= S_PAD;
            end
          end
        end
        S_PAD: begin
          mark_q <= 1'b1;
          if (use_len) begin
            in_len_q <= 1'b1;
            len_k_q  <= len_k_q + 3'd1;
            if (len_k_q == 3'd7) begin
              fin_q <= 1'b1;
            end
          end
          if (push_full) begin
            rnd_q   <= '0;
            state_q <= S_ROUND;
          end
        end
        S_ROUND: begin
          rnd_q <= rnd_q + 7'd1;
          if (rnd_q == sha1mh_pkg::RoundLast) begin
            state_q <= S_FOLD;
          end
        end
        S_FOLD: begin
          chain_q[0] <= chain_q[0] + a_q;
          chain_q[1] <= chain_q[1] + b_q;
          chain_q[2] <= chain_q[2] + c_q;
          chain_q[3] <= chain_q[3] + d_q;
          chain_q[4] <= chain_q[4] + e_q;
          if (fin_q) begin
            widx_q    <= '0;
            out_vld_q <= 1'b1;
            state_q   <= S_OUT;
          end else if (pad_q) begin
            state_q <= S_PAD;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_OUT: begin
          if (m_axis_tready_i) begin
            if (widx_q == sha1mh_pkg::LastIdx) begin
              // Digest delivered: start the next message from scratch.
              out_vld_q <= 1'b0;
              chain_q   <= sha1mh_pkg::HInit;
              cnt_q     <= '0;
              pad_q     <= 1'b0;
              mark_q    <= 1'b0;
              in_len_q  <= 1'b0;
              fin_q     <= 1'b0;
              len_k_q   <= '0;
              state_q   <= S_IDLE;
            end else begin
              widx_q <= widx_q + 3'd1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      blk_q <= {blk_q[503:0], push_byte};
    end else if (state_q == S_ROUND) begin
      blk_q <= {blk_q[479:0], w_new};
    end
    if (state_q == S_PAD && !mark_q) begin
      len_q <= {cnt_q, 3'b000};
    end
    if (push_full) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
      e_q <= chain_q[4];
    end else if (state_q == S_ROUND) begin
      a_q <= t_sum;
      b_q <= a_q;
      c_q <= rotl(b_q, 5'd30);
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = chain_q[widx_q];
  assign m_axis_tuser_o  = widx_q;
  assign m_axis_tlast_o  = (widx_q == sha1mh_pkg::LastIdx);

  `SHA1MH_ASSERT(a_rnd_range, (state_q == S_ROUND) |-> (rnd_q <= sha1mh_pkg::RoundLast))
  `SHA1MH_ASSERT(a_last_idx, (out_vld_q && m_axis_tready_i && m_axis_tlast_o) |=> !out_vld_q)
  `SHA1MH_ASSERT(a_len_at_end, (state_q == S_PAD && use_len && len_k_q == 3'd7) |-> push_full)

endmodule
